>>> rtl/core/line_edit_buffer_defines.svh
// assertion macros used by the checker of the line edit buffer
`ifndef LINE_EDIT_BUFFER_DEFINES_SVH
`define LINE_EDIT_BUFFER_DEFINES_SVH

// same-cycle implication, quiet during reset
`define LEB_ASSERT_NOW(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define LEB_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/leb_pkg.sv
package leb_pkg;

  localparam int LINE_DEPTH = 64;
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = $clog2(LINE_DEPTH + 1);

  localparam logic [BYTE_W-1:0] KEY_HOME  = 8'h5B;
  localparam logic [BYTE_W-1:0] KEY_END   = 8'h5D;
  localparam logic [BYTE_W-1:0] KEY_LEFT  = 8'h7B;
  localparam logic [BYTE_W-1:0] KEY_RIGHT = 8'h7D;
  localparam logic [BYTE_W-1:0] KEY_MODE  = 8'h2D;
  localparam logic [BYTE_W-1:0] KEY_DEL   = 8'h3D;
  localparam logic [BYTE_W-1:0] KEY_NL    = 8'h0A;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_op_t;

endpackage

>>> rtl/core/line_edit_buffer.sv
// edit keys and text bytes are accepted while idle, key_ready stays high between lines
// an accepted newline then emits one beat per cycle from the head
// cell while text_ready is high: line_length beats, or one beat for an empty line
// keys are held off until the last beat of the line is in the output register
// rst (synchronous) clears length, cursor, mode, dropped flag and the output valid;
// the character cells are not reset
module line_edit_buffer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         key_valid,
  output logic                         key_ready,
  input  logic [leb_pkg::BYTE_W-1:0]   key_byte,
  output logic                         text_valid,
  input  logic                         text_ready,
  output logic [leb_pkg::BYTE_W-1:0]   text_byte,
  output logic                         last,
  output logic                         empty_line,
  output logic                         dropped
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  localparam logic [leb_pkg::LEN_W-1:0] DEPTH_LEN = leb_pkg::LEN_W'(leb_pkg::LINE_DEPTH);
  localparam logic [leb_pkg::LEN_W-1:0] ONE_LEN   = leb_pkg::LEN_W'(1);

  state_t                        state;
  logic [leb_pkg::LEN_W-1:0]     line_length;
  logic [leb_pkg::LEN_W-1:0]     cursor_pos;
  logic                          overwrite_mode;
  logic                          overflow_seen;
  logic [leb_pkg::LEN_W-1:0]     remain;
  logic                          line_dropped;

  logic [leb_pkg::BYTE_W-1:0]    cell_data [leb_pkg::LINE_DEPTH];
  leb_pkg::cell_op_t             cell_op   [leb_pkg::LINE_DEPTH];

  logic key_fire, is_text, ow_hit;
  logic do_insert, do_overwrite, do_drop, do_delete;
  logic out_free, emit_step, emit_shift;

  assign key_ready = (state == ST_IDLE);
  assign key_fire  = key_valid && key_ready;

  assign is_text = (key_byte != leb_pkg::KEY_HOME)  && (key_byte != leb_pkg::KEY_END)  &&
                   (key_byte != leb_pkg::KEY_LEFT)  && (key_byte != leb_pkg::KEY_RIGHT) &&
                   (key_byte != leb_pkg::KEY_MODE)  && (key_byte != leb_pkg::KEY_DEL)  &&
                   (key_byte != leb_pkg::KEY_NL);
  assign ow_hit  = overwrite_mode && (cursor_pos < line_length);

  assign do_overwrite = key_fire && is_text && ow_hit;
  assign do_insert    = key_fire && is_text && !ow_hit && (line_length < DEPTH_LEN);
  assign do_drop      = key_fire && is_text && !ow_hit && (line_length >= DEPTH_LEN);
  assign do_delete    = key_fire && (key_byte == leb_pkg::KEY_DEL) && (cursor_pos != '0);

  assign out_free   = !text_valid || text_ready;
  assign emit_step  = (state == ST_EMIT) && out_free;
  assign emit_shift = emit_step && (remain != '0);

  for (genvar i = 0; i < leb_pkg::LINE_DEPTH; i++) begin : g_cell
    localparam logic [leb_pkg::LEN_W-1:0] IDX  = leb_pkg::LEN_W'(i);
    localparam logic [leb_pkg::LEN_W-1:0] IDX1 = leb_pkg::LEN_W'(i + 1);
    logic [leb_pkg::BYTE_W-1:0] left_in, right_in;

    if (i == 0) begin : g_head
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end
    if (i == leb_pkg::LINE_DEPTH - 1) begin : g_tail
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end

    always_comb begin
      cell_op[i] = leb_pkg::CELL_HOLD;
      if (emit_shift) begin
        // emission drains the row toward the head cell
        cell_op[i] = leb_pkg::CELL_FROM_RIGHT;
      end else if (do_insert) begin
        if (IDX > cursor_pos) begin
          cell_op[i] = leb_pkg::CELL_FROM_LEFT;
        end else if (IDX == cursor_pos) begin
          cell_op[i] = leb_pkg::CELL_LOAD;
        end
      end else if (do_overwrite) begin
        if (IDX == cursor_pos) begin
          cell_op[i] = leb_pkg::CELL_LOAD;
        end
      end else if (do_delete) begin
        // cells from cursor-1 upward close the gap
        if (IDX1 >= cursor_pos) begin
          cell_op[i] = leb_pkg::CELL_FROM_RIGHT;
        end
      end
    end

    leb_cell u_cell (
      .clk        (clk),
      .op         (cell_op[i]),
      .load_byte  (key_byte),
      .left_byte  (left_in),
      .right_byte (right_in),
      .data       (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      line_length    <= '0;
      cursor_pos     <= '0;
      overwrite_mode <= 1'b0;
      overflow_seen  <= 1'b0;
      remain         <= '0;
      line_dropped   <= 1'b0;
      text_valid     <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (key_fire) begin
            case (key_byte)
              leb_pkg::KEY_HOME:  cursor_pos <= '0;
              leb_pkg::KEY_END:   cursor_pos <= line_length;
              leb_pkg::KEY_LEFT: begin
                if (cursor_pos != '0) cursor_pos <= cursor_pos - ONE_LEN;
              end
              leb_pkg::KEY_RIGHT: begin
                if (cursor_pos < line_length) cursor_pos <= cursor_pos + ONE_LEN;
              end
              leb_pkg::KEY_MODE:  overwrite_mode <= !overwrite_mode;
              leb_pkg::KEY_DEL: begin
                if (do_delete) begin
                  cursor_pos  <= cursor_pos - ONE_LEN;
                  line_length <= line_length - ONE_LEN;
                end
              end
              leb_pkg::KEY_NL: begin
                remain         <= line_length;
                line_dropped   <= overflow_seen;
                line_length    <= '0;
                cursor_pos     <= '0;
                overwrite_mode <= 1'b0;
                overflow_seen  <= 1'b0;
                state          <= ST_EMIT;
              end
              default: begin
                if (do_overwrite) begin
                  cursor_pos <= cursor_pos + ONE_LEN;
                end else if (do_insert) begin
                  cursor_pos  <= cursor_pos + ONE_LEN;
                  line_length <= line_length + ONE_LEN;
                end else if (do_drop) begin
                  overflow_seen <= 1'b1;
                end
              end
            endcase
          end
        end
        ST_EMIT: begin
          if (emit_step) begin
            if (remain <= ONE_LEN) state <= ST_IDLE;
            if (remain != '0) remain <= remain - ONE_LEN;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (emit_step) begin
        text_valid <= 1'b1;
      end else if (text_ready) begin
        text_valid <= 1'b0;
      end
    end
  end

  // output payload, loaded once per beat
  always_ff @(posedge clk) begin
    if (emit_step) begin
      dropped <= line_dropped;
      if (remain == '0) begin
        text_byte  <= '0;
        last       <= 1'b1;
        empty_line <= 1'b1;
      end else begin
        text_byte  <= cell_data[0];
        last       <= (remain == ONE_LEN);
        empty_line <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/leb_cell.sv
module leb_cell (
  input  logic                         clk,
  input  leb_pkg::cell_op_t            op,
  input  logic [leb_pkg::BYTE_W-1:0]   load_byte,
  input  logic [leb_pkg::BYTE_W-1:0]   left_byte,
  input  logic [leb_pkg::BYTE_W-1:0]   right_byte,
  output logic [leb_pkg::BYTE_W-1:0]   data
);

  always_ff @(posedge clk) begin
    case (op)
      leb_pkg::CELL_HOLD:       data <= data;
      leb_pkg::CELL_LOAD:       data <= load_byte;
      leb_pkg::CELL_FROM_LEFT:  data <= left_byte;
      leb_pkg::CELL_FROM_RIGHT: data <= right_byte;
      default:                  data <= data;
    endcase
  end

endmodule

>>> rtl/core/leb_checker.sv
`include "line_edit_buffer_defines.svh"

module leb_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         key_valid,
  input logic                         key_ready,
  input logic [leb_pkg::BYTE_W-1:0]   key_byte,
  input logic                         text_valid,
  input logic                         text_ready,
  input logic [leb_pkg::BYTE_W-1:0]   text_byte,
  input logic                         last,
  input logic                         empty_line,
  input logic                         dropped
);

  // a stalled beat keeps its payload
  `LEB_ASSERT_NEXT(a_out_hold, clk, rst, text_valid && !text_ready, text_valid && $stable(text_byte) && $stable(last) && $stable(empty_line) && $stable(dropped), "stalled text beat changed")

  // an empty line is always a single, final beat
  `LEB_ASSERT_NOW(a_empty_last, clk, rst, text_valid && empty_line, last, "empty line beat without last")

  // keys are held off while a line is still draining
  `LEB_ASSERT_NOW(a_no_key_mid_line, clk, rst, text_valid && !last, !key_ready, "key ready in the middle of a line")

  // a newline blocks keys in the next cycle
  `LEB_ASSERT_NEXT(a_nl_blocks, clk, rst, key_valid && key_ready && key_byte == leb_pkg::KEY_NL, !key_ready, "key ready right after newline")

  // no beat straight out of reset
  `LEB_ASSERT_NOW(a_reset_quiet, clk, rst, $past(rst), !text_valid, "text beat right after reset")

endmodule

bind line_edit_buffer leb_checker u_leb_checker (.*);
